// ----- rtl/ifd_pkg.sv -----
// Shared types, codes and helper functions of the IPv4 forwarding decision block.
package ifd_pkg;

    localparam int ROUTE_ENTRIES_DEF = 64;
    localparam int ARP_ENTRIES_DEF   = 16;

    localparam int ROUTE_WORD_W = 74;  // prefix, length, port, next hop
    localparam int ARP_WORD_W   = 80;  // address, MAC

    typedef enum logic [1:0] {
        OP_ROUTE  = 2'd0,
        OP_ARP    = 2'd1,
        OP_FWD    = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        V_FORWARD = 3'd0,
        V_BADSUM  = 3'd1,
        V_UNREACH = 3'd2,
        V_ARPNEED = 3'd3,
        V_TTLEXC  = 3'd4,
        V_WRITTEN = 3'd5,
        V_FULL    = 3'd6
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RRD,
        S_RCMP,
        S_ARD,
        S_ACMP,
        S_FIN
    } t_state;

    // One classified item as it waits in the queue between front and back.
    typedef struct packed {
        t_op         op;
        logic [31:0] addr;     // masked prefix or ARP address
        logic [5:0]  len;      // saturated prefix length
        logic [3:0]  port;
        logic [31:0] hop;
        logic [47:0] mac;
        logic        badsum;
        logic [31:0] dst;
        logic        ttl_low;  // TTL of zero or one
        logic [7:0]  new_ttl;
        logic [15:0] new_cks;
    } t_cmd;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic [3:0]  port;
        logic [31:0] hop;
    } t_route;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_arp;

    // Mask with the top len bits set; lengths above 32 act as 32.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        m = 32'd0;
        for (int b = 0; b < 32; b++) begin
            if (6'(32 - b) <= len) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    // Two end-around carry folds of a ones'-complement sum.
    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] a;
        logic [16:0] b;
        a = 17'(s[15:0]) + 17'(s[19:16]);
        b = 17'(a[15:0]) + 17'(a[16]);
        return b[15:0];
    endfunction

endpackage

// ----- rtl/ifd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ifd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ifd_front.sv -----
// Front end: accepts items, checks the header checksum, classifies and queues them.
module ifd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_operation,
    input  logic [31:0]   i_address,
    input  logic [5:0]    i_prefix_len,
    input  logic [3:0]    i_out_port,
    input  logic [31:0]   i_next_hop,
    input  logic [47:0]   i_mac_address,
    input  logic [63:0]   i_header_high,
    input  logic [63:0]   i_header_middle,
    input  logic [31:0]   i_header_low,
    input  logic          i_pop,
    output logic          o_avail,
    output ifd_pkg::t_cmd o_cmd
);

    ifd_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    ifd_pkg::t_cmd n_cmd;
    logic [19:0]   sum;
    logic [15:0]   hc;
    logic [7:0]    ttl;
    logic [15:0]   m_old;
    logic [15:0]   m_new;
    logic [17:0]   upd;
    logic [5:0]    len_sat;
    logic          push;
    logic          pop;

    // Classification: checksum check, prefix masking and incremental checksum update.
    always_comb begin
        hc  = i_header_middle[47:32];
        ttl = i_header_middle[63:56];
        sum = 20'(i_header_high[63:48]) + 20'(i_header_high[47:32])
            + 20'(i_header_high[31:16]) + 20'(i_header_high[15:0])
            + 20'(i_header_middle[63:48]) + 20'(i_header_middle[31:16])
            + 20'(i_header_middle[15:0]) + 20'(i_header_low[31:16])
            + 20'(i_header_low[15:0]);
        m_old   = i_header_middle[63:48];
        m_new   = {ttl - 8'd1, i_header_middle[55:48]};
        upd     = 18'(16'(~hc)) + 18'(16'(~m_old)) + 18'(m_new);
        len_sat = (i_prefix_len > 6'd32) ? 6'd32 : i_prefix_len;

        n_cmd.op      = ifd_pkg::t_op'(i_operation);
        n_cmd.addr    = (i_operation == ifd_pkg::OP_ROUTE)
                      ? (i_address & ifd_pkg::len_mask(len_sat)) : i_address;
        n_cmd.len     = len_sat;
        n_cmd.port    = i_out_port;
        n_cmd.hop     = i_next_hop;
        n_cmd.mac     = i_mac_address;
        n_cmd.badsum  = (~ifd_pkg::fold16(sum)) != hc;
        n_cmd.dst     = i_header_low;
        n_cmd.ttl_low = ttl <= 8'd1;
        n_cmd.new_ttl = ttl - 8'd1;
        n_cmd.new_cks = ~ifd_pkg::fold16(20'(upd));
    end

    // Two-entry queue; the unused operation is accepted and dropped.
    assign o_in_ready = r_cnt != 2'd2;
    assign push       = i_in_valid && o_in_ready && (i_operation != ifd_pkg::OP_UNUSED);
    assign pop        = i_pop && (r_cnt != 2'd0);
    assign o_avail    = r_cnt != 2'd0;
    assign o_cmd      = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/ifd_back.sv -----
// Back end: scans the route and ARP tables, updates them and produces the result item.
module ifd_back #(
    parameter int ROUTE_ENTRIES = ifd_pkg::ROUTE_ENTRIES_DEF,
    parameter int ARP_ENTRIES   = ifd_pkg::ARP_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  ifd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_verdict,
    output logic [3:0]    o_egress_port,
    output logic [47:0]   o_dest_mac,
    output logic [31:0]   o_gateway,
    output logic [7:0]    o_new_ttl,
    output logic [15:0]   o_new_checksum
);

    localparam int RAW  = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int AAW  = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
    localparam int RCW  = $clog2(ROUTE_ENTRIES + 1);
    localparam int ACW  = $clog2(ARP_ENTRIES + 1);
    localparam int MAXE = (ROUTE_ENTRIES > ARP_ENTRIES) ? ROUTE_ENTRIES : ARP_ENTRIES;
    localparam int CW   = $clog2(MAXE + 1);
    localparam int ROUTE_WORD_W_L = ifd_pkg::ROUTE_WORD_W;

    ifd_pkg::t_state r_state, n_state;
    ifd_pkg::t_cmd   r_cmd, n_cmd;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_hit_idx, n_hit_idx;
    logic            r_hit, n_hit;
    logic            r_found, n_found;
    logic [5:0]      r_best_len, n_best_len;
    logic [3:0]      r_best_port, n_best_port;
    logic [31:0]     r_best_hop, n_best_hop;
    logic            r_mhit, n_mhit;
    logic [47:0]     r_mac, n_mac;
    logic [RCW-1:0]  r_rcount, n_rcount;
    logic [ACW-1:0]  r_acount, n_acount;

    logic            r_out_valid;
    logic [2:0]      r_verdict, n_verdict;
    logic [3:0]      r_port, n_port;
    logic [47:0]     r_dmac, n_dmac;
    logic [31:0]     r_gw, n_gw;
    logic [7:0]      r_ttl, n_ttl;
    logic [15:0]     r_cks, n_cks;
    logic            emit;

    logic            r_we, a_we;
    logic [RAW-1:0]  r_waddr;
    logic [AAW-1:0]  a_waddr;
    logic [ROUTE_WORD_W_L-1:0] r_wdata;
    logic [ifd_pkg::ARP_WORD_W-1:0] a_wdata;
    logic [ROUTE_WORD_W_L-1:0] r_rdata;
    logic [ifd_pkg::ARP_WORD_W-1:0] a_rdata;
    ifd_pkg::t_route rent;
    ifd_pkg::t_arp   aent;
    logic [31:0]     akey;
    logic [CW-1:0]   idx_next;

    ifd_ram #(.WIDTH(ROUTE_WORD_W_L), .DEPTH(ROUTE_ENTRIES), .AW(RAW)) u_route_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_raddr (r_idx[RAW-1:0]),
        .o_rdata (r_rdata)
    );

    ifd_ram #(.WIDTH(ifd_pkg::ARP_WORD_W), .DEPTH(ARP_ENTRIES), .AW(AAW)) u_arp_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (r_idx[AAW-1:0]),
        .o_rdata (a_rdata)
    );

    assign rent     = ifd_pkg::t_route'(r_rdata);
    assign aent     = ifd_pkg::t_arp'(a_rdata);
    assign akey     = (r_cmd.op == ifd_pkg::OP_ARP) ? r_cmd.addr : r_best_hop;
    assign idx_next = r_idx + CW'(1);

    // Sequencer: next state, scan bookkeeping, table writes and the result.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_hit_idx   = r_hit_idx;
        n_hit       = r_hit;
        n_found     = r_found;
        n_best_len  = r_best_len;
        n_best_port = r_best_port;
        n_best_hop  = r_best_hop;
        n_mhit      = r_mhit;
        n_mac       = r_mac;
        n_rcount    = r_rcount;
        n_acount    = r_acount;
        o_pop       = 1'b0;
        emit        = 1'b0;
        r_we        = 1'b0;
        a_we        = 1'b0;
        r_waddr     = r_rcount[RAW-1:0];
        a_waddr     = r_acount[AAW-1:0];
        r_wdata     = {r_cmd.addr, r_cmd.len, r_cmd.port, r_cmd.hop};
        a_wdata     = {r_cmd.addr, r_cmd.mac};
        n_verdict   = ifd_pkg::V_WRITTEN;
        n_port      = 4'd0;
        n_dmac      = 48'd0;
        n_gw        = 32'd0;
        n_ttl       = 8'd0;
        n_cks       = 16'd0;

        case (r_state)
            ifd_pkg::S_IDLE: begin
                if (i_avail) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_found = 1'b0;
                    n_mhit  = 1'b0;
                    case (i_cmd.op)
                        ifd_pkg::OP_ARP: begin
                            n_state = (r_acount == '0) ? ifd_pkg::S_FIN : ifd_pkg::S_ARD;
                        end
                        ifd_pkg::OP_FWD: begin
                            n_state = (i_cmd.badsum || r_rcount == '0)
                                    ? ifd_pkg::S_FIN : ifd_pkg::S_RRD;
                        end
                        default: begin
                            n_state = (r_rcount == '0) ? ifd_pkg::S_FIN : ifd_pkg::S_RRD;
                        end
                    endcase
                end
            end
            ifd_pkg::S_RRD: begin
                n_state = ifd_pkg::S_RCMP;
            end
            ifd_pkg::S_RCMP: begin
                // Exact match for a load, longest prefix for a forward.
                if (r_cmd.op == ifd_pkg::OP_ROUTE) begin
                    if (!r_hit && rent.prefix == r_cmd.addr && rent.len == r_cmd.len) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_idx;
                    end
                end else if ((r_cmd.dst & ifd_pkg::len_mask(rent.len)) == rent.prefix
                             && (!r_found || rent.len > r_best_len)) begin
                    n_found     = 1'b1;
                    n_best_len  = rent.len;
                    n_best_port = rent.port;
                    n_best_hop  = rent.hop;
                end
                n_idx = idx_next;
                if (idx_next == CW'(r_rcount)) begin
                    if (r_cmd.op == ifd_pkg::OP_FWD && n_found && r_acount != '0) begin
                        n_idx   = '0;
                        n_state = ifd_pkg::S_ARD;
                    end else begin
                        n_state = ifd_pkg::S_FIN;
                    end
                end else begin
                    n_state = ifd_pkg::S_RRD;
                end
            end
            ifd_pkg::S_ARD: begin
                n_state = ifd_pkg::S_ACMP;
            end
            ifd_pkg::S_ACMP: begin
                // First ARP entry whose address equals the key.
                if (!r_mhit && aent.ip == akey) begin
                    n_mhit = 1'b1;
                    n_mac  = aent.mac;
                end
                n_idx   = idx_next;
                n_state = (idx_next == CW'(r_acount)) ? ifd_pkg::S_FIN : ifd_pkg::S_ARD;
            end
            ifd_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    emit    = 1'b1;
                    n_state = ifd_pkg::S_IDLE;
                    case (r_cmd.op)
                        ifd_pkg::OP_ROUTE: begin
                            if (r_hit) begin
                                r_we    = 1'b1;
                                r_waddr = r_hit_idx[RAW-1:0];
                            end else if (r_rcount == RCW'(ROUTE_ENTRIES)) begin
                                n_verdict = ifd_pkg::V_FULL;
                            end else begin
                                r_we     = 1'b1;
                                n_rcount = r_rcount + RCW'(1);
                            end
                        end
                        ifd_pkg::OP_ARP: begin
                            if (r_mhit) begin
                                n_verdict = ifd_pkg::V_WRITTEN;
                            end else if (r_acount == ACW'(ARP_ENTRIES)) begin
                                n_verdict = ifd_pkg::V_FULL;
                            end else begin
                                a_we     = 1'b1;
                                n_acount = r_acount + ACW'(1);
                            end
                        end
                        default: begin
                            if (r_cmd.badsum) begin
                                n_verdict = ifd_pkg::V_BADSUM;
                            end else if (!r_found) begin
                                n_verdict = ifd_pkg::V_UNREACH;
                            end else begin
                                n_port = r_best_port;
                                n_gw   = r_best_hop;
                                if (!r_mhit) begin
                                    n_verdict = ifd_pkg::V_ARPNEED;
                                end else begin
                                    n_dmac = r_mac;
                                    if (r_cmd.ttl_low) begin
                                        n_verdict = ifd_pkg::V_TTLEXC;
                                    end else begin
                                        n_verdict = ifd_pkg::V_FORWARD;
                                        n_ttl     = r_cmd.new_ttl;
                                        n_cks     = r_cmd.new_cks;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = ifd_pkg::S_IDLE;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_hit_idx   <= n_hit_idx;
        r_hit       <= n_hit;
        r_found     <= n_found;
        r_best_len  <= n_best_len;
        r_best_port <= n_best_port;
        r_best_hop  <= n_best_hop;
        r_mhit      <= n_mhit;
        r_mac       <= n_mac;
        if (!i_rst_n) begin
            r_state  <= ifd_pkg::S_IDLE;
            r_rcount <= '0;
            r_acount <= '0;
        end else begin
            r_state  <= n_state;
            r_rcount <= n_rcount;
            r_acount <= n_acount;
        end
    end

    // Output register: holds a result item until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_verdict <= n_verdict;
            r_port    <= n_port;
            r_dmac    <= n_dmac;
            r_gw      <= n_gw;
            r_ttl     <= n_ttl;
            r_cks     <= n_cks;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_egress_port  = r_port;
    assign o_dest_mac     = r_dmac;
    assign o_gateway      = r_gw;
    assign o_new_ttl      = r_ttl;
    assign o_new_checksum = r_cks;

endmodule

// ----- rtl/ipv4_forwarding_decision.sv -----
// Top level of the IPv4 forwarding decision block.
//
// Input channel (i_in_valid / o_in_ready): one item per handshake. Operation 0
// loads a route, operation 1 inserts an ARP entry if its address is new, and
// operation 2 judges a 20-byte IPv4 header. Operation 3 is accepted and dropped.
// Output channel (o_out_valid / i_out_ready): one result item per operation 0,
// 1 or 2, in input order.
// The front end checks the checksum, masks the prefix and queues up to two
// items; the back end scans the tables one entry at a time through the
// single read port of each table RAM, with a read state and a compare state
// per entry. A route load scans the R stored routes, an ARP insert the A ARP
// entries and a header at most both, where R and A are the numbers of stored
// routes and ARP entries. A header with a bad checksum skips the table scan.
// Reset empties both tables (their counts go to zero) and the queue; no
// clearing pass is needed. When the receiver stalls, the result waits in the
// output register, the back end holds its next result in S_FIN, and the front
// end keeps taking items until its queue is full.
module ipv4_forwarding_decision #(
    parameter int ROUTE_ENTRIES = ifd_pkg::ROUTE_ENTRIES_DEF,
    parameter int ARP_ENTRIES   = ifd_pkg::ARP_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_len,
    input  logic [3:0]  i_out_port,
    input  logic [31:0] i_next_hop,
    input  logic [47:0] i_mac_address,
    input  logic [63:0] i_header_high,
    input  logic [63:0] i_header_middle,
    input  logic [31:0] i_header_low,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_verdict,
    output logic [3:0]  o_egress_port,
    output logic [47:0] o_dest_mac,
    output logic [31:0] o_gateway,
    output logic [7:0]  o_new_ttl,
    output logic [15:0] o_new_checksum
);

    logic          avail;
    logic          pop;
    ifd_pkg::t_cmd cmd;

    ifd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_address       (i_address),
        .i_prefix_len    (i_prefix_len),
        .i_out_port      (i_out_port),
        .i_next_hop      (i_next_hop),
        .i_mac_address   (i_mac_address),
        .i_header_high   (i_header_high),
        .i_header_middle (i_header_middle),
        .i_header_low    (i_header_low),
        .i_pop           (pop),
        .o_avail         (avail),
        .o_cmd           (cmd)
    );

    ifd_back #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .ARP_ENTRIES   (ARP_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (avail),
        .i_cmd          (cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_verdict      (o_verdict),
        .o_egress_port  (o_egress_port),
        .o_dest_mac     (o_dest_mac),
        .o_gateway      (o_gateway),
        .o_new_ttl      (o_new_ttl),
        .o_new_checksum (o_new_checksum)
    );

endmodule

// ----- sim/fwd_checker.sv -----
// Checker that predicts and compares the forwarding decisions of the block.
`timescale 1ns / 100ps

module fwd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_len,
    input  logic [3:0]  i_out_port,
    input  logic [31:0] i_next_hop,
    input  logic [47:0] i_mac_address,
    input  logic [63:0] i_header_high,
    input  logic [63:0] i_header_middle,
    input  logic [31:0] i_header_low,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_verdict,
    input  logic [3:0]  i_egress_port,
    input  logic [47:0] i_dest_mac,
    input  logic [31:0] i_gateway,
    input  logic [7:0]  i_new_ttl,
    input  logic [15:0] i_new_checksum,
    output int          o_errors,
    output int          o_pending
);
    localparam int ROUTES = ifd_pkg::ROUTE_ENTRIES_DEF;
    localparam int ARPS   = ifd_pkg::ARP_ENTRIES_DEF;

    typedef struct packed {
        ifd_pkg::t_verdict verdict;
        logic [3:0]  port;
        logic [47:0] mac;
        logic [31:0] gw;
        logic [7:0]  ttl;
        logic [15:0] cks;
    } t_decision;

    t_decision   decisions_due[$];
    logic [31:0] rt_prefix[ROUTES];
    logic [5:0]  rt_len[ROUTES];
    logic [3:0]  rt_port[ROUTES];
    logic [31:0] rt_hop[ROUTES];
    int          rt_count;
    logic [31:0] nb_ip[ARPS];
    logic [47:0] nb_mac[ARPS];
    int          nb_count;

    initial o_pending = 0;

    // Mask with the top len bits set.
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        if (len == 0) return 32'd0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        return s[15:0];
    endfunction

    // Computes the decision for one item and updates the tables.
    function automatic t_decision decide(input ifd_pkg::t_op op, input logic [31:0] addr,
            input logic [5:0] plen, input logic [3:0] port, input logic [31:0] hop,
            input logic [47:0] mac, input logic [63:0] hh, input logic [63:0] hm,
            input logic [31:0] hl);
        t_decision   d;
        logic [5:0]  len;
        logic [31:0] pfx;
        logic [31:0] s;
        logic [15:0] hc;
        logic [15:0] m_old;
        logic [15:0] m_new;
        logic [7:0]  ttl;
        int          best;
        int          hit;
        d = '0;
        case (op)
            ifd_pkg::OP_ROUTE: begin
                len = (plen > 32) ? 6'd32 : plen;
                pfx = addr & prefix_mask(len);
                hit = -1;
                for (int i = 0; i < rt_count; i++)
                    if (hit < 0 && rt_prefix[i] == pfx && rt_len[i] == len) hit = i;
                d.verdict = ifd_pkg::V_WRITTEN;
                if (hit >= 0) begin
                    rt_port[hit] = port;
                    rt_hop[hit] = hop;
                end else if (rt_count >= ROUTES) begin
                    d.verdict = ifd_pkg::V_FULL;
                end else begin
                    rt_prefix[rt_count] = pfx;
                    rt_len[rt_count] = len;
                    rt_port[rt_count] = port;
                    rt_hop[rt_count] = hop;
                    rt_count++;
                end
            end
            ifd_pkg::OP_ARP: begin
                hit = 0;
                for (int i = 0; i < nb_count; i++) if (nb_ip[i] == addr) hit = 1;
                d.verdict = ifd_pkg::V_WRITTEN;
                if (!hit) begin
                    if (nb_count >= ARPS) begin
                        d.verdict = ifd_pkg::V_FULL;
                    end else begin
                        nb_ip[nb_count] = addr;
                        nb_mac[nb_count] = mac;
                        nb_count++;
                    end
                end
            end
            default: begin
                s = hh[63:48] + hh[47:32] + hh[31:16] + hh[15:0] + hm[63:48]
                    + hm[31:16] + hm[15:0] + hl[31:16] + hl[15:0];
                hc = hm[47:32];
                ttl = hm[63:56];
                if (~ones_fold(s) != hc) begin
                    d.verdict = ifd_pkg::V_BADSUM;
                    return d;
                end
                best = -1;
                for (int i = 0; i < rt_count; i++)
                    if ((hl & prefix_mask(rt_len[i])) == rt_prefix[i]
                            && (best < 0 || rt_len[i] > rt_len[best])) best = i;
                if (best < 0) begin
                    d.verdict = ifd_pkg::V_UNREACH;
                    return d;
                end
                d.port = rt_port[best];
                d.gw = rt_hop[best];
                hit = -1;
                for (int i = 0; i < nb_count; i++)
                    if (hit < 0 && nb_ip[i] == d.gw) hit = i;
                if (hit < 0) begin
                    d.verdict = ifd_pkg::V_ARPNEED;
                    return d;
                end
                d.mac = nb_mac[hit];
                if (ttl <= 1) begin
                    d.verdict = ifd_pkg::V_TTLEXC;
                    return d;
                end
                m_old = {ttl, hm[55:48]};
                m_new = {ttl - 8'd1, hm[55:48]};
                s = 32'(16'(~hc)) + 32'(16'(~m_old)) + 32'(m_new);
                d.verdict = ifd_pkg::V_FORWARD;
                d.ttl = ttl - 8'd1;
                d.cks = ~ones_fold(s);
            end
        endcase
        return d;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
            input logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    t_decision want;

    // Predict on accepted input items and compare accepted result items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rt_count = 0;
            nb_count = 0;
            o_errors = 0;
        end else begin
            if (i_in_valid && i_in_ready && ifd_pkg::t_op'(i_operation) != ifd_pkg::OP_UNUSED)
                decisions_due.push_back(decide(ifd_pkg::t_op'(i_operation), i_address,
                    i_prefix_len, i_out_port, i_next_hop, i_mac_address,
                    i_header_high, i_header_middle, i_header_low));
            if (i_out_valid && i_out_ready) begin
                if (decisions_due.size() == 0) begin
                    report("unexpected result item", i_verdict, 0);
                end else begin
                    want = decisions_due.pop_front();
                    if (i_verdict !== want.verdict) report("verdict", i_verdict, want.verdict);
                    if (i_egress_port !== want.port) report("egress_port", i_egress_port, want.port);
                    if (i_dest_mac !== want.mac) report("dest_mac", i_dest_mac, want.mac);
                    if (i_gateway !== want.gw) report("gateway", i_gateway, want.gw);
                    if (i_new_ttl !== want.ttl) report("new_ttl", i_new_ttl, want.ttl);
                    if (i_new_checksum !== want.cks)
                        report("new_checksum", i_new_checksum, want.cks);
                end
            end
        end
        o_pending = decisions_due.size();
    end
endmodule

// ----- sim/tb_top.sv -----
// Testbench top: stimulus for the IPv4 forwarding decision block and the verdict.
`timescale 1ns / 100ps

module tb_top;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = ifd_pkg::OP_UNUSED;
    logic [31:0] i_address = '0;
    logic [5:0]  i_prefix_len = '0;
    logic [3:0]  i_out_port = '0;
    logic [31:0] i_next_hop = '0;
    logic [47:0] i_mac_address = '0;
    logic [63:0] i_header_high = '0;
    logic [63:0] i_header_middle = '0;
    logic [31:0] i_header_low = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_verdict;
    logic [3:0]  o_egress_port;
    logic [47:0] o_dest_mac;
    logic [31:0] o_gateway;
    logic [7:0]  o_new_ttl;
    logic [15:0] o_new_checksum;
    int          errors;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    int          cycle_count = 0;
    logic [31:0] hops[8];
    logic [31:0] dests[8];

    always #5 i_clk = ~i_clk;

    ipv4_forwarding_decision dut (.*);

    fwd_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_operation,
        .i_address, .i_prefix_len, .i_out_port, .i_next_hop, .i_mac_address,
        .i_header_high, .i_header_middle, .i_header_low, .i_out_valid(o_out_valid),
        .i_out_ready, .i_verdict(o_verdict), .i_egress_port(o_egress_port),
        .i_dest_mac(o_dest_mac), .i_gateway(o_gateway), .i_new_ttl(o_new_ttl),
        .i_new_checksum(o_new_checksum), .o_errors(errors), .o_pending(pending)
    );

    // Run limit: ends a run that goes on too long as failed; the tables hold 80 entries in all.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Presents one item and waits until it is taken. Ready only changes at the
    // rising edge, so its value at the falling edge holds for the next rising edge.
    task automatic send(input ifd_pkg::t_op op, input logic [31:0] addr,
            input logic [5:0] plen, input logic [3:0] port, input logic [31:0] hop,
            input logic [47:0] mac, input logic [63:0] hh, input logic [63:0] hm,
            input logic [31:0] hl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_address <= addr;
        i_prefix_len <= plen;
        i_out_port <= port;
        i_next_hop <= hop;
        i_mac_address <= mac;
        i_header_high <= hh;
        i_header_middle <= hm;
        i_header_low <= hl;
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sends a header with the given destination and TTL, checksum right or broken.
    task automatic send_header(input logic [31:0] dst, input logic [7:0] ttl,
            input logic bad);
        logic [63:0] hh;
        logic [63:0] hm;
        logic [31:0] s;
        hh = {$urandom, $urandom};
        hm = {ttl, 8'($urandom), 16'h0, 32'($urandom)};
        s = hh[63:48] + hh[47:32] + hh[31:16] + hh[15:0] + hm[63:48]
            + hm[31:16] + hm[15:0] + dst[31:16] + dst[15:0];
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        hm[47:32] = ~s[15:0];
        if (bad) hm[47:32] = hm[47:32] ^ 16'(1 << $urandom_range(15));
        send(ifd_pkg::OP_FWD, $urandom, 6'($urandom), 4'($urandom), $urandom,
             {$urandom, $urandom}, hh, hm, dst);
    endtask

    // Stops offering items and waits until every result item has come.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // One random item, mostly well-formed forwarding traffic.
    task automatic random_item;
        int k;
        k = $urandom_range(99);
        if (k < 10)
            send(ifd_pkg::OP_ROUTE, dests[$urandom_range(7)] ^ $urandom_range(255),
                 6'($urandom_range(8, 33)), 4'($urandom), hops[$urandom_range(7)],
                 0, 0, 0, 0);
        else if (k < 18)
            send(ifd_pkg::OP_ARP,
                 ($urandom_range(3) == 0) ? $urandom : hops[$urandom_range(7)],
                 0, 0, 0, {$urandom, $urandom}, 0, 0, 0);
        else if (k < 21)
            send(ifd_pkg::OP_UNUSED, $urandom, 6'($urandom), 4'($urandom), $urandom,
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        else if (k < 26)
            send(ifd_pkg::t_op'($urandom_range(2)), $urandom, 6'($urandom), 4'($urandom),
                 $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, $urandom);
        else
            send_header(($urandom_range(4) == 0) ? $urandom
                        : dests[$urandom_range(7)] ^ $urandom_range(0, 65535),
                        ($urandom_range(5) == 0) ? 8'($urandom_range(2)) : 8'($urandom),
                        $urandom_range(9) == 0);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            hops[i] = $urandom;
            dests[i] = $urandom;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, default route, extremes, ARP cases, TTL cases.
        send_header(32'h0A000001, 8'd64, 1'b0);
        send_header(32'h0A000001, 8'd64, 1'b1);
        send(ifd_pkg::OP_ROUTE, 32'hFFFF_FFFF, 6'd0, 4'hF, hops[0], 0, 0, 0, 0);
        send(ifd_pkg::OP_ROUTE, 32'hFFFF_FFFF, 6'd63, 4'h0, hops[1], 0, 0, 0, 0);
        send(ifd_pkg::OP_ROUTE, 32'hC0A8_01FF, 6'd24, 4'h5, hops[2], 0, 0, 0, 0);
        send(ifd_pkg::OP_ROUTE, 32'hC0A8_0100, 6'd24, 4'h9, hops[3], 0, 0, 0, 0);
        send(ifd_pkg::OP_ROUTE, 32'hFFFF_FFFF, 6'd32, 4'h3, 32'h0, 0, 0, 0, 0);
        send_header(32'hC0A8_0107, 8'd64, 1'b0);
        send(ifd_pkg::OP_ARP, hops[3], 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
        send(ifd_pkg::OP_ARP, hops[3], 0, 0, 0, 48'h0, 0, 0, 0);
        send(ifd_pkg::OP_ARP, 32'h0, 0, 0, 0, 48'h0, 0, 0, 0);
        send(ifd_pkg::OP_ARP, hops[0], 0, 0, 0, 48'h1234_5678_9ABC, 0, 0, 0);
        send_header(32'hC0A8_0107, 8'd255, 1'b0);
        send_header(32'hC0A8_0107, 8'd1, 1'b0);
        send_header(32'hC0A8_0107, 8'd0, 1'b0);
        send_header(32'hC0A8_0107, 8'd2, 1'b0);
        send_header(32'hFFFF_FFFF, 8'd9, 1'b0);
        send_header(32'h0000_0000, 8'd9, 1'b0);
        send(ifd_pkg::OP_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1);
        send(ifd_pkg::OP_FWD, '1, '1, '1, '1, '1, '1, '1, '1);
        send(ifd_pkg::OP_FWD, 0, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // Random phases with different idle patterns.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? 73 : ((ph == 2) ? 31 : 0);
            recv_stall_pct = (ph == 2 || ph == 3) ? 73 : 0;
            if (ph == 3) send_idle_pct = 31;
            if (ph == 3) recv_stall_pct = 31;
            if (ph == 1) begin
                hold_cycles = 3000;
                send_idle_pct = 0;
                repeat (8) random_item();
                send_idle_pct = 73;
            end
            repeat (300) random_item();
            // Pause until every result has come.
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (60) send(ifd_pkg::OP_ROUTE, $urandom, 6'($urandom_range(33)), 4'($urandom),
                         $urandom, 0, 0, 0, 0);
        repeat (20) send(ifd_pkg::OP_ARP, $urandom, 0, 0, 0, {$urandom, $urandom}, 0, 0, 0);
        repeat (40) random_item();
        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- ipv4_forwarding_decision.f -----
rtl/ifd_pkg.sv
rtl/ifd_ram.sv
rtl/ifd_front.sv
rtl/ifd_back.sv
rtl/ipv4_forwarding_decision.sv
sim/fwd_checker.sv
sim/tb_top.sv
